[sv/binary_max_heap_assert.svh]
// assertion macros shared by the heap checker
`ifndef BINARY_MAX_HEAP_ASSERT_SVH
`define BINARY_MAX_HEAP_ASSERT_SVH

// same-cycle implication on the rising clock edge, idle during reset
`define BMH_ASSERT_SAME(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// next-cycle implication on the rising clock edge, idle during reset
`define BMH_ASSERT_NEXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

[sv/bmh_pkg.sv]
// shared types and constants for the binary max-heap
`default_nettype none

package bmh_pkg;

	localparam int DEF_CAPACITY = 1024;
	localparam int KEY_W        = 32;
	localparam int COUNT_OUT_W  = 11;

	// operation codes carried in the input word
	typedef enum logic [1:0] {
		MODE_PUSH   = 2'd0,
		MODE_POP    = 2'd1,
		MODE_APPEND = 2'd2,
		MODE_BUILD  = 2'd3
	} mode_t;

	// result status codes
	typedef enum logic [1:0] {
		STAT_OK        = 2'd0,
		STAT_POP_EMPTY = 2'd1,
		STAT_FULL      = 2'd2
	} status_t;

	// controller states
	typedef enum logic [3:0] {
		S_IDLE,
		S_PUSH_CMP,
		S_POP_KEY,
		S_BLD_NEXT,
		S_BLD_RD,
		S_DN_L,
		S_DN_CMP,
		S_FIN,
		S_DONE
	} state_t;

	typedef struct packed {
		mode_t                    mode;
		logic signed [KEY_W-1:0]  key_in;
	} in_word_t;

	typedef struct packed {
		logic signed [KEY_W-1:0]   max_key;
		logic                      is_empty;
		logic [COUNT_OUT_W-1:0]    entry_count;
		status_t                   status;
	} out_word_t;

endpackage

`default_nettype wire

[sv/bmh_ram.sv]
// generic single-port-write, single-port-read ram with registered read
`default_nettype none

module bmh_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 1024
) (
	input  wire logic                     clk,
	input  wire logic                     we,
	input  wire logic [$clog2(DEPTH)-1:0] waddr,
	input  wire logic [WIDTH-1:0]         wdata,
	input  wire logic [$clog2(DEPTH)-1:0] raddr,
	output logic      [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	// write port
	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
	end

	// registered read port
	always_ff @(posedge clk) begin
		rdata <= mem[raddr];
	end

endmodule

`default_nettype wire

[sv/bmh_ctrl.sv]
// heap sequencer: push sift-up, pop and build sift-down over the key ram
`default_nettype none

module bmh_ctrl #(
	parameter int CAPACITY = bmh_pkg::DEF_CAPACITY
) (
	input  wire logic                      clk,
	input  wire logic                      arst_n,
	input  wire logic                      in_valid,
	output logic                           in_ready,
	input  wire bmh_pkg::in_word_t         in_word,
	output logic                           res_valid,
	input  wire logic                      res_ready,
	output bmh_pkg::out_word_t             res_word,
	output logic                           ram_we,
	output logic [$clog2(CAPACITY)-1:0]    ram_waddr,
	output logic [bmh_pkg::KEY_W-1:0]      ram_wdata,
	output logic [$clog2(CAPACITY)-1:0]    ram_raddr,
	input  wire logic [bmh_pkg::KEY_W-1:0] ram_rdata
);

	localparam int ADDR_W = $clog2(CAPACITY);
	localparam int CNT_W  = $clog2(CAPACITY + 1);
	localparam int POS_W  = CNT_W + 1;

	// 1-based heap position to ram index
	function automatic logic [ADDR_W-1:0] pos_to_idx(input logic [POS_W-1:0] p);
		logic [POS_W-1:0] t;
		t = p - 1'b1;
		return t[ADDR_W-1:0];
	endfunction

	bmh_pkg::state_t  state_q, state_d;
	bmh_pkg::mode_t   mode_q, mode_d;
	bmh_pkg::status_t status_q, status_d;
	logic [CNT_W-1:0] count_q, count_d;
	logic [CNT_W-1:0] pos_q, pos_d;
	logic [CNT_W-1:0] bld_q, bld_d;
	logic             has_right_q, has_right_d;
	logic signed [bmh_pkg::KEY_W-1:0] key_q, key_d;
	logic signed [bmh_pkg::KEY_W-1:0] left_q, left_d;
	logic signed [bmh_pkg::KEY_W-1:0] root_q;
	logic signed [bmh_pkg::KEY_W-1:0] rd_key;

	logic [POS_W-1:0] lc_pos, rc_pos, half_cnt, best_pos;
	logic [CNT_W-1:0] up_pos;
	logic             left_gt, right_gt, child_move, accept;
	logic signed [bmh_pkg::KEY_W-1:0] best_val, move_val;
	bmh_pkg::state_t  sift_end;

	assign rd_key   = ram_rdata;
	assign accept   = in_valid && in_ready;
	assign in_ready = (state_q == bmh_pkg::S_IDLE);

	// child positions and sift-down compare against the held key
	assign lc_pos     = {pos_q, 1'b0};
	assign rc_pos     = {pos_q, 1'b1};
	assign half_cnt   = POS_W'(count_q >> 1);
	assign left_gt    = left_q > key_q;
	assign best_val   = left_gt ? left_q : key_q;
	assign right_gt   = has_right_q && (rd_key > best_val);
	assign child_move = left_gt || right_gt;
	assign best_pos   = right_gt ? rc_pos : lc_pos;
	assign move_val   = right_gt ? rd_key : left_q;
	assign up_pos     = pos_q >> 1;
	assign sift_end   = (mode_q == bmh_pkg::MODE_BUILD) ? bmh_pkg::S_BLD_NEXT
	                                                    : bmh_pkg::S_DONE;

	// result word
	assign res_valid            = (state_q == bmh_pkg::S_DONE);
	assign res_word.max_key     = (count_q == '0) ? '0 : root_q;
	assign res_word.is_empty    = (count_q == '0);
	assign res_word.entry_count = bmh_pkg::COUNT_OUT_W'(count_q);
	assign res_word.status      = status_q;

	// next state, ram access and register updates
	always_comb begin
		state_d     = state_q;
		mode_d      = mode_q;
		status_d    = status_q;
		count_d     = count_q;
		pos_d       = pos_q;
		bld_d       = bld_q;
		has_right_d = has_right_q;
		key_d       = key_q;
		left_d      = left_q;
		ram_we      = 1'b0;
		ram_waddr   = '0;
		ram_wdata   = key_q;
		ram_raddr   = '0;
		unique case (state_q)
			bmh_pkg::S_IDLE: begin
				if (accept) begin
					mode_d   = in_word.mode;
					status_d = bmh_pkg::STAT_OK;
					key_d    = in_word.key_in;
					unique case (in_word.mode)
						bmh_pkg::MODE_PUSH, bmh_pkg::MODE_APPEND: begin
							if (count_q == CNT_W'(CAPACITY)) begin
								status_d = bmh_pkg::STAT_FULL;
								state_d  = bmh_pkg::S_DONE;
							end else if (in_word.mode == bmh_pkg::MODE_APPEND ||
							             count_q == '0) begin
								ram_we    = 1'b1;
								ram_waddr = ADDR_W'(count_q);
								ram_wdata = in_word.key_in;
								count_d   = count_q + 1'b1;
								state_d   = bmh_pkg::S_DONE;
							end else begin
								count_d   = count_q + 1'b1;
								pos_d     = count_q + 1'b1;
								ram_raddr = pos_to_idx(POS_W'((count_q + 1'b1) >> 1));
								state_d   = bmh_pkg::S_PUSH_CMP;
							end
						end
						bmh_pkg::MODE_POP: begin
							if (count_q == '0) begin
								status_d = bmh_pkg::STAT_POP_EMPTY;
								state_d  = bmh_pkg::S_DONE;
							end else begin
								ram_raddr = pos_to_idx({1'b0, count_q});
								count_d   = count_q - 1'b1;
								state_d   = bmh_pkg::S_POP_KEY;
							end
						end
						bmh_pkg::MODE_BUILD: begin
							bld_d   = count_q >> 1;
							state_d = bmh_pkg::S_BLD_NEXT;
						end
					endcase
				end
			end
			// parent word is on the read port
			bmh_pkg::S_PUSH_CMP: begin
				if (rd_key < key_q) begin
					ram_we    = 1'b1;
					ram_waddr = pos_to_idx({1'b0, pos_q});
					ram_wdata = rd_key;
					pos_d     = up_pos;
					if (up_pos > CNT_W'(1)) begin
						ram_raddr = pos_to_idx(POS_W'(up_pos >> 1));
					end else begin
						state_d = bmh_pkg::S_FIN;
					end
				end else begin
					ram_we    = 1'b1;
					ram_waddr = pos_to_idx({1'b0, pos_q});
					state_d   = bmh_pkg::S_DONE;
				end
			end
			// last word is on the read port, it becomes the root unless the heap is now empty
			bmh_pkg::S_POP_KEY: begin
				if (count_q == '0) begin
					state_d = bmh_pkg::S_DONE;
				end else if (count_q >= CNT_W'(2)) begin
					key_d     = rd_key;
					pos_d     = CNT_W'(1);
					ram_raddr = pos_to_idx(POS_W'(2));
					state_d   = bmh_pkg::S_DN_L;
				end else begin
					ram_we    = 1'b1;
					ram_waddr = '0;
					ram_wdata = rd_key;
					state_d   = bmh_pkg::S_DONE;
				end
			end
			// next internal node of a build, walking toward the root
			bmh_pkg::S_BLD_NEXT: begin
				if (bld_q == '0) begin
					state_d = bmh_pkg::S_DONE;
				end else begin
					ram_raddr = pos_to_idx({1'b0, bld_q});
					state_d   = bmh_pkg::S_BLD_RD;
				end
			end
			bmh_pkg::S_BLD_RD: begin
				key_d     = rd_key;
				pos_d     = bld_q;
				bld_d     = bld_q - 1'b1;
				ram_raddr = pos_to_idx({bld_q, 1'b0});
				state_d   = bmh_pkg::S_DN_L;
			end
			// left child arrives, fetch the right one
			bmh_pkg::S_DN_L: begin
				left_d      = rd_key;
				has_right_d = (rc_pos <= {1'b0, count_q});
				ram_raddr   = pos_to_idx(rc_pos);
				state_d     = bmh_pkg::S_DN_CMP;
			end
			// pick the larger child and move it up, or settle the key here
			bmh_pkg::S_DN_CMP: begin
				ram_we    = 1'b1;
				ram_waddr = pos_to_idx({1'b0, pos_q});
				if (child_move) begin
					ram_wdata = move_val;
					pos_d     = best_pos[CNT_W-1:0];
					if (best_pos <= half_cnt) begin
						ram_raddr = pos_to_idx({best_pos[CNT_W-1:0], 1'b0});
						state_d   = bmh_pkg::S_DN_L;
					end else begin
						state_d = bmh_pkg::S_FIN;
					end
				end else begin
					state_d = sift_end;
				end
			end
			bmh_pkg::S_FIN: begin
				ram_we    = 1'b1;
				ram_waddr = pos_to_idx({1'b0, pos_q});
				state_d   = sift_end;
			end
			bmh_pkg::S_DONE: begin
				if (res_ready) begin
					state_d = bmh_pkg::S_IDLE;
				end
			end
			default: begin
				state_d = bmh_pkg::S_IDLE;
			end
		endcase
	end

	// control registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= bmh_pkg::S_IDLE;
			count_q <= '0;
		end else begin
			state_q <= state_d;
			count_q <= count_d;
		end
	end

	// datapath registers
	always_ff @(posedge clk) begin
		mode_q      <= mode_d;
		status_q    <= status_d;
		pos_q       <= pos_d;
		bld_q       <= bld_d;
		has_right_q <= has_right_d;
		key_q       <= key_d;
		left_q      <= left_d;
		if (ram_we && ram_waddr == '0) begin
			root_q <= ram_wdata;
		end
	end

endmodule

`default_nettype wire

[sv/binary_max_heap.sv]
// Binary max-heap of signed 32-bit keys held in one synchronous ram.
// One word is worked at a time; the single ram read port sets the pace.
// Append, dropped insert and ignored pop go straight to the result; push sifts up,
// pop and build sift keys down, build walking the internal nodes back toward the root.
// The next word is accepted once the result is registered. Reset clears the entry count,
// controller state and output valid; ram contents are not cleared and need no pass.
`default_nettype none

module binary_max_heap #(
	parameter int CAPACITY = bmh_pkg::DEF_CAPACITY
) (
	input  wire logic               clk,
	input  wire logic               arst_n,
	input  wire logic               in_valid,
	output logic                    in_ready,
	input  wire bmh_pkg::in_word_t  in_word,
	output logic                    out_valid,
	input  wire logic               out_ready,
	output bmh_pkg::out_word_t      out_word
);

	localparam int ADDR_W = $clog2(CAPACITY);

	logic                       ram_we;
	logic [ADDR_W-1:0]          ram_waddr, ram_raddr;
	logic [bmh_pkg::KEY_W-1:0]  ram_wdata, ram_rdata;
	logic                       res_valid, res_ready;
	bmh_pkg::out_word_t         res_word;
	logic                       out_valid_q;
	bmh_pkg::out_word_t         out_word_q;

	bmh_ctrl #(
		.CAPACITY (CAPACITY)
	) u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_ready  (in_ready),
		.in_word   (in_word),
		.res_valid (res_valid),
		.res_ready (res_ready),
		.res_word  (res_word),
		.ram_we    (ram_we),
		.ram_waddr (ram_waddr),
		.ram_wdata (ram_wdata),
		.ram_raddr (ram_raddr),
		.ram_rdata (ram_rdata)
	);

	bmh_ram #(
		.WIDTH (bmh_pkg::KEY_W),
		.DEPTH (CAPACITY)
	) u_ram (
		.clk   (clk),
		.we    (ram_we),
		.waddr (ram_waddr),
		.wdata (ram_wdata),
		.raddr (ram_raddr),
		.rdata (ram_rdata)
	);

	// output register, loads when empty or being drained
	assign res_ready = !out_valid_q || out_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (res_ready) begin
			out_valid_q <= res_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (res_valid && res_ready) begin
			out_word_q <= res_word;
		end
	end

	assign out_valid = out_valid_q;
	assign out_word  = out_word_q;

endmodule

`default_nettype wire

[sv/bmh_checker.sv]
// port-level checker for the binary max-heap, bound to the top level
`default_nettype none

`include "binary_max_heap_assert.svh"

module bmh_checker (
	input wire logic               clk,
	input wire logic               arst_n,
	input wire logic               in_valid,
	input wire logic               in_ready,
	input wire logic               out_valid,
	input wire logic               out_ready,
	input wire bmh_pkg::out_word_t out_word
);

	// a stalled result word holds
	`BMH_ASSERT_NEXT(a_out_hold, out_valid && !out_ready, out_valid && $stable(out_word), "result word changed while stalled")

	// one word in work at a time
	`BMH_ASSERT_NEXT(a_one_in_flight, in_valid && in_ready, !in_ready, "input taken while a word is in work")

	// empty heap reports zero key and zero count
	`BMH_ASSERT_SAME(a_empty_zero, out_valid && out_word.is_empty, out_word.max_key == '0 && out_word.entry_count == '0, "empty result with nonzero key or count")

	// an ignored pop leaves the heap empty
	`BMH_ASSERT_SAME(a_pop_empty, out_valid && out_word.status == bmh_pkg::STAT_POP_EMPTY, out_word.is_empty, "pop flagged empty on a nonempty heap")

	// a dropped insert means the heap holds entries
	`BMH_ASSERT_SAME(a_full_nonempty, out_valid && out_word.status == bmh_pkg::STAT_FULL, !out_word.is_empty, "full flag on an empty heap")

endmodule

bind binary_max_heap bmh_checker u_bmh_checker (
	.clk       (clk),
	.arst_n    (arst_n),
	.in_valid  (in_valid),
	.in_ready  (in_ready),
	.out_valid (out_valid),
	.out_ready (out_ready),
	.out_word  (out_word)
);

`default_nettype wire

[tb/sv/tb_binary_max_heap.sv]
// self-checking testbench for the binary max-heap: queued words, random idling, heap predictor
`timescale 1ns / 100ps

module tb_binary_max_heap;

	localparam int HEAP_CAP = bmh_pkg::DEF_CAPACITY;
	localparam logic signed [bmh_pkg::KEY_W-1:0] KEY_MAX = 32'sh7fff_ffff;
	localparam logic signed [bmh_pkg::KEY_W-1:0] KEY_MIN = 32'sh8000_0000;
	localparam int RANDOM_WORDS = 50;
	localparam int TAIL_CYCLES = 200;
	localparam int RUN_LIMIT_NS = 6_000_000;

	// one queued input word; drain_first holds it back until all results are in
	typedef struct {
		bmh_pkg::in_word_t w;
		bit                drain_first;
	} plan_item_t;

	logic               clk = 1'b0;
	logic               arst_n = 1'b0;
	logic               in_valid = 1'b0;
	logic               in_ready;
	bmh_pkg::in_word_t  in_word = '0;
	logic               out_valid;
	logic               out_ready = 1'b0;
	bmh_pkg::out_word_t out_word;

	plan_item_t         word_plan[$];
	bmh_pkg::out_word_t pending_results[$];
	int                 plan_count = 0;
	int                 fail_count = 0;

	// predictor copy of the heap, 1-based positions
	logic signed [bmh_pkg::KEY_W-1:0] heap_keys [1:HEAP_CAP];
	int heap_fill = 0;

	int unsigned drv_gap = 0;
	int unsigned drv_calm = 0;
	int unsigned mon_gap = 0;
	int unsigned mon_calm = 0;

	binary_max_heap #(
		.CAPACITY(HEAP_CAP)
	) u_top (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.in_ready (in_ready),
		.in_word  (in_word),
		.out_valid(out_valid),
		.out_ready(out_ready),
		.out_word (out_word)
	);

	// clock and reset
	initial begin
		forever #1 clk = ~clk;
	end

	initial begin
		repeat (10) @(posedge clk);
		arst_n <= 1'b1;
	end

	// move a key up past strictly smaller parents
	function automatic void sift_toward_root(int p);
		logic signed [bmh_pkg::KEY_W-1:0] t;
		while (p > 1 && heap_keys[p / 2] < heap_keys[p]) begin
			t = heap_keys[p / 2];
			heap_keys[p / 2] = heap_keys[p];
			heap_keys[p] = t;
			p = p / 2;
		end
	endfunction

	// move a key down below strictly larger children, right child only if strictly larger
	function automatic void sift_toward_leaves(int p);
		int big;
		bit moving;
		logic signed [bmh_pkg::KEY_W-1:0] t;
		moving = 1'b1;
		while (moving) begin
			big = p;
			if (2 * p <= heap_fill && heap_keys[2 * p] > heap_keys[big])
				big = 2 * p;
			if (2 * p + 1 <= heap_fill && heap_keys[2 * p + 1] > heap_keys[big])
				big = 2 * p + 1;
			if (big == p) begin
				moving = 1'b0;
			end else begin
				t = heap_keys[big];
				heap_keys[big] = heap_keys[p];
				heap_keys[p] = t;
				p = big;
			end
		end
	endfunction

	// apply one accepted word to the heap copy and return the expected result word
	function automatic bmh_pkg::out_word_t apply_word(bmh_pkg::in_word_t w);
		bmh_pkg::out_word_t r;
		r = '0;
		r.status = bmh_pkg::STAT_OK;
		case (w.mode)
			bmh_pkg::MODE_PUSH, bmh_pkg::MODE_APPEND: begin
				if (heap_fill >= HEAP_CAP) begin
					r.status = bmh_pkg::STAT_FULL;
				end else begin
					heap_fill++;
					heap_keys[heap_fill] = w.key_in;
					if (w.mode == bmh_pkg::MODE_PUSH)
						sift_toward_root(heap_fill);
				end
			end
			bmh_pkg::MODE_POP: begin
				if (heap_fill == 0) begin
					r.status = bmh_pkg::STAT_POP_EMPTY;
				end else begin
					heap_keys[1] = heap_keys[heap_fill];
					heap_fill--;
					sift_toward_leaves(1);
				end
			end
			default: begin
				for (int i = heap_fill / 2; i >= 1; i--)
					sift_toward_leaves(i);
			end
		endcase
		r.is_empty = (heap_fill == 0);
		r.max_key = (heap_fill == 0) ? '0 : heap_keys[1];
		r.entry_count = bmh_pkg::COUNT_OUT_W'(heap_fill);
		return r;
	endfunction

	// idle length: mostly short, a few long
	function automatic int unsigned pick_gap();
		int unsigned roll;
		roll = $urandom_range(0, 99);
		if (roll < 60)
			return $urandom_range(1, 2);
		if (roll < 90)
			return $urandom_range(3, 8);
		return $urandom_range(20, 60);
	endfunction

	// keys: full range, tight range for ties, extremes, moderate values
	function automatic logic signed [bmh_pkg::KEY_W-1:0] pick_key();
		int unsigned roll;
		roll = $urandom_range(0, 99);
		if (roll < 40)
			return $urandom;
		if (roll < 60)
			return int'($urandom_range(0, 8)) - 4;
		if (roll < 70) begin
			case ($urandom_range(0, 3))
				0: return KEY_MAX;
				1: return KEY_MIN;
				2: return 0;
				default: return -1;
			endcase
		end
		return int'($urandom_range(0, 2000)) - 1000;
	endfunction

	// queue a word and track the entry count it will leave behind
	function automatic void add_word(bmh_pkg::mode_t m, logic signed [bmh_pkg::KEY_W-1:0] k,
		bit hold);
		plan_item_t it;
		it.w.mode = m;
		it.w.key_in = k;
		it.drain_first = hold;
		word_plan.push_back(it);
		if ((m == bmh_pkg::MODE_PUSH || m == bmh_pkg::MODE_APPEND) && plan_count < HEAP_CAP)
			plan_count++;
		else if (m == bmh_pkg::MODE_POP && plan_count > 0)
			plan_count--;
	endfunction

	// input side: present queued words, predict on accept
	always @(posedge clk or negedge arst_n) begin : drive_proc
		plan_item_t nxt;
		if (!arst_n) begin
			in_valid <= 1'b0;
			in_word <= '0;
			drv_gap <= 0;
			drv_calm <= 0;
		end else begin
			if (in_valid && in_ready)
				pending_results.push_back(apply_word(in_word));
			if (in_valid && !in_ready) begin
				// word still waiting, hold it
			end else if (drv_gap != 0) begin
				drv_gap <= drv_gap - 1;
				in_valid <= 1'b0;
			end else if (word_plan.size() != 0 &&
				!(word_plan[0].drain_first && pending_results.size() != 0)) begin
				nxt = word_plan.pop_front();
				in_word <= nxt.w;
				in_valid <= 1'b1;
				if (drv_calm != 0)
					drv_calm <= drv_calm - 1;
				else if ($urandom_range(0, 99) < 3)
					drv_calm <= $urandom_range(20, 80);
				else if ($urandom_range(0, 99) < 35)
					drv_gap <= pick_gap();
			end else begin
				in_valid <= 1'b0;
			end
		end
	end

	// output side: random back-pressure, compare each result word with the oldest prediction
	always @(posedge clk or negedge arst_n) begin : watch_proc
		bmh_pkg::out_word_t want;
		if (!arst_n) begin
			out_ready <= 1'b0;
			mon_gap <= 0;
			mon_calm <= 0;
		end else begin
			if (out_valid && out_ready) begin
				if (pending_results.size() == 0) begin
					fail_count++;
					if (fail_count <= 10)
						$display("unexpected result: key %0d empty %0d count %0d status %0d",
							out_word.max_key, out_word.is_empty, out_word.entry_count,
							out_word.status);
				end else begin
					want = pending_results.pop_front();
					if (out_word.max_key !== want.max_key ||
						out_word.is_empty !== want.is_empty ||
						out_word.entry_count !== want.entry_count ||
						out_word.status !== want.status) begin
						fail_count++;
						if (fail_count <= 10)
							$display({"mismatch: expected key %0d empty %0d count %0d status %0d,",
								" got key %0d empty %0d count %0d status %0d"},
								want.max_key, want.is_empty, want.entry_count, want.status,
								out_word.max_key, out_word.is_empty, out_word.entry_count,
								out_word.status);
					end
				end
			end
			if (mon_gap != 0) begin
				mon_gap <= mon_gap - 1;
				out_ready <= 1'b0;
			end else begin
				out_ready <= 1'b1;
				if (mon_calm != 0)
					mon_calm <= mon_calm - 1;
				else if ($urandom_range(0, 99) < 3)
					mon_calm <= $urandom_range(20, 80);
				else if ($urandom_range(0, 99) < 25)
					mon_gap <= pick_gap();
			end
		end
	end

	// stimulus plan and end of run
	initial begin : stim_proc
		int made;
		int unsigned roll;
		int burst;
		bmh_pkg::mode_t op;

		// empty heap, single entry, extremes, ties, appends repaired by build
		add_word(bmh_pkg::MODE_POP, 0, 1'b0);
		add_word(bmh_pkg::MODE_BUILD, 0, 1'b0);
		add_word(bmh_pkg::MODE_PUSH, 0, 1'b0);
		add_word(bmh_pkg::MODE_BUILD, 0, 1'b0);
		add_word(bmh_pkg::MODE_PUSH, KEY_MAX, 1'b0);
		add_word(bmh_pkg::MODE_PUSH, KEY_MIN, 1'b0);
		add_word(bmh_pkg::MODE_PUSH, -1, 1'b0);
		add_word(bmh_pkg::MODE_PUSH, 5, 1'b0);
		add_word(bmh_pkg::MODE_PUSH, 5, 1'b0);
		add_word(bmh_pkg::MODE_APPEND, -100, 1'b0);
		add_word(bmh_pkg::MODE_APPEND, KEY_MAX, 1'b0);
		add_word(bmh_pkg::MODE_BUILD, 0, 1'b1);
		while (plan_count > 0)
			add_word(bmh_pkg::MODE_POP, 0, 1'b0);
		add_word(bmh_pkg::MODE_POP, 0, 1'b0);

		// fill to capacity, then full-heap cases
		while (plan_count < HEAP_CAP)
			add_word(($urandom_range(0, 1) != 0) ? bmh_pkg::MODE_PUSH : bmh_pkg::MODE_APPEND,
				pick_key(), 1'b0);
		add_word(bmh_pkg::MODE_PUSH, pick_key(), 1'b0);
		add_word(bmh_pkg::MODE_APPEND, pick_key(), 1'b0);
		add_word(bmh_pkg::MODE_BUILD, 0, 1'b1);
		add_word(bmh_pkg::MODE_PUSH, KEY_MAX, 1'b0);

		// random mix around a nearly full heap
		made = 0;
		while (made < RANDOM_WORDS) begin
			roll = $urandom_range(0, 99);
			if (roll < 5) begin
				// raw appends repaired by a build
				burst = $urandom_range(3, 10);
				repeat (burst)
					add_word(bmh_pkg::MODE_APPEND, pick_key(), 1'b0);
				add_word(bmh_pkg::MODE_BUILD, 0, 1'b0);
				made += burst + 1;
			end else begin
				roll = $urandom_range(0, 99);
				if (plan_count == 0)
					op = (roll < 50) ? bmh_pkg::MODE_PUSH :
						(roll < 80) ? bmh_pkg::MODE_APPEND :
						(roll < 90) ? bmh_pkg::MODE_POP : bmh_pkg::MODE_BUILD;
				else if (plan_count > 64)
					op = (roll < 60) ? bmh_pkg::MODE_POP :
						(roll < 85) ? bmh_pkg::MODE_PUSH :
						(roll < 95) ? bmh_pkg::MODE_APPEND : bmh_pkg::MODE_BUILD;
				else
					op = (roll < 45) ? bmh_pkg::MODE_PUSH :
						(roll < 75) ? bmh_pkg::MODE_POP :
						(roll < 92) ? bmh_pkg::MODE_APPEND : bmh_pkg::MODE_BUILD;
				add_word(op, pick_key(), $urandom_range(0, 99) < 2);
				made++;
			end
		end

		// wait for all words to go in and all results to come out
		@(posedge arst_n);
		while (word_plan.size() != 0 || in_valid)
			@(posedge clk);
		while (pending_results.size() != 0)
			@(posedge clk);
		repeat (TAIL_CYCLES) @(posedge clk);

		if (fail_count == 0 && pending_results.size() == 0)
			$display("TB_OK");
		else
			$display("TB_ERROR");
		$finish;
	end

	// run limit
	initial begin
		#(RUN_LIMIT_NS);
		$display("TB_ERROR");
		$finish;
	end

endmodule
